// File: sv/ieq_pkg.sv
// ----------------------------------------------------------------------------
// ieq_pkg
// Shared codes, defaults and controller/datapath interface types for the
// input event queue.
// ----------------------------------------------------------------------------
package ieq_pkg;

    localparam int QUEUE_DEPTH_DEF = 128;
    localparam int COORD_WIDTH_DEF = 16;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 72;

    // item action codes
    localparam logic [1:0] ACT_KEY   = 2'd0;
    localparam logic [1:0] ACT_MOUSE = 2'd1;
    localparam logic [1:0] ACT_POLL  = 2'd2;

    // event type codes
    localparam logic [2:0] EVT_KEY_PRESS   = 3'd0;
    localparam logic [2:0] EVT_KEY_RELEASE = 3'd1;
    localparam logic [2:0] EVT_BTN_PRESS   = 3'd2;
    localparam logic [2:0] EVT_BTN_RELEASE = 3'd3;
    localparam logic [2:0] EVT_MOTION      = 3'd4;

    // mouse sequence steps: three button bits, then the move check
    localparam logic [1:0] STEP_MOVE = 2'd3;

    typedef struct packed {
        logic       load_in;     // capture the accepted item
        logic       push_key;    // try to enqueue the key event
        logic       push_mouse;  // try to enqueue the event of mouse step
        logic [1:0] step;
        logic       upd_last;    // commit new position and buttons
        logic       rd;          // dequeue oldest event if any
        logic       load_out;    // load the result register
    } ieq_cmd_t;

    typedef struct packed {
        logic [1:0] in_action;   // action field of the offered item
        logic       out_free;    // result register can take a new result
    } ieq_status_t;

endpackage

// File: sv/ieq_ctrl.sv
// ----------------------------------------------------------------------------
// ieq_ctrl
// Sequencer: accepts an item, steps the datapath through its queue writes or
// its read, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ieq_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ieq_pkg::ieq_status_t status,
    output ieq_pkg::ieq_cmd_t    cmd
);
    import ieq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_KEY   = 3'd1;
    localparam logic [2:0] S_MOUSE = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] step_reg, step_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cmd            = '0;
        cmd.step       = step_reg;
        cmd.load_in    = accept;
        unique case (state_reg)
            S_IDLE:
            begin
                step_next = 2'd0;
                if (accept)
                begin
                    unique case (status.in_action)
                        ACT_KEY:   state_next = S_KEY;
                        ACT_MOUSE: state_next = S_MOUSE;
                        ACT_POLL:  state_next = S_READ;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_KEY:
            begin
                cmd.push_key = 1'b1;
                state_next   = S_DONE;
            end
            S_MOUSE:
            begin
                cmd.push_mouse = 1'b1;
                step_next      = step_reg + 2'd1;
                if (step_reg == STEP_MOVE)
                begin
                    cmd.upd_last = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// File: sv/ieq_datapath.sv
// ----------------------------------------------------------------------------
// ieq_datapath
// Item register, event memory with pointers, last mouse state, edge/move
// detection and the result register.
// ----------------------------------------------------------------------------
module ieq_datapath
#(
    parameter int QUEUE_DEPTH = ieq_pkg::QUEUE_DEPTH_DEF,
    parameter int COORD_WIDTH = ieq_pkg::COORD_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [ieq_pkg::IN_DATA_W-1:0]     in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ieq_pkg::OUT_DATA_W-1:0]    out_data,
    input  ieq_pkg::ieq_cmd_t                 cmd,
    output ieq_pkg::ieq_status_t              status
);
    import ieq_pkg::*;

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int PTR_W   = IDX_W + 1;
    localparam int ENTRY_W = 27 + 2 * COORD_WIDTH;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] x;
        logic [7:0]                    btn;
        logic [7:0]                    chr;
        logic [7:0]                    code;
        logic [2:0]                    kind;
    } entry_t;

    // input fields
    logic [1:0]         f_action;
    logic [7:0]         f_scancode;
    logic               f_key_down;
    logic [7:0]         f_key_char;
    logic signed [15:0] f_mouse_x;
    logic signed [15:0] f_mouse_y;
    logic [7:0]         f_buttons;

    assign f_action   = in_data[1:0];
    assign f_scancode = in_data[9:2];
    assign f_key_down = in_data[10];
    assign f_key_char = in_data[18:11];
    assign f_mouse_x  = in_data[34:19];
    assign f_mouse_y  = in_data[50:35];
    assign f_buttons  = in_data[58:51];

    // item register
    logic [7:0]                    scancode_reg;
    logic                          key_down_reg;
    logic [7:0]                    key_char_reg;
    logic signed [COORD_WIDTH-1:0] nx_reg;
    logic signed [COORD_WIDTH-1:0] ny_reg;
    logic [7:0]                    nb_reg;

    // queue state
    logic [ENTRY_W-1:0]            mem [QUEUE_DEPTH];
    entry_t                        rd_q;
    logic [PTR_W-1:0]              wr_ptr_reg, rd_ptr_reg;
    logic signed [COORD_WIDTH-1:0] last_x_reg, last_y_reg;
    logic [7:0]                    last_btn_reg;

    logic [2:0] pushed_reg, dropped_reg;
    logic       got_reg;

    logic   full, empty, need, push_go, do_write;
    logic [2:0] changed;
    entry_t wr_entry;

    logic               out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p[IDX_W-1:0] == IDX_LAST)
            r = {~p[PTR_W-1], {IDX_W{1'b0}}};
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    assign empty   = (wr_ptr_reg == rd_ptr_reg);
    assign full    = (wr_ptr_reg[IDX_W-1:0] == rd_ptr_reg[IDX_W-1:0]) &&
                     (wr_ptr_reg[PTR_W-1] != rd_ptr_reg[PTR_W-1]);
    assign changed = nb_reg[2:0] ^ last_btn_reg[2:0];

    always_comb
    begin
        need     = 1'b0;
        wr_entry = '0;
        if (cmd.push_key)
        begin
            need          = 1'b1;
            wr_entry.kind = key_down_reg ? EVT_KEY_PRESS : EVT_KEY_RELEASE;
            wr_entry.code = scancode_reg;
            wr_entry.chr  = key_down_reg ? key_char_reg : 8'd0;
            wr_entry.btn  = last_btn_reg;
            wr_entry.x    = last_x_reg;
            wr_entry.y    = last_y_reg;
        end
        else
        begin
            wr_entry.btn = nb_reg;
            wr_entry.x   = nx_reg;
            wr_entry.y   = ny_reg;
            if (cmd.step == STEP_MOVE)
            begin
                need          = (nx_reg != last_x_reg) || (ny_reg != last_y_reg);
                wr_entry.kind = EVT_MOTION;
            end
            else
            begin
                need          = changed[cmd.step];
                wr_entry.kind = nb_reg[cmd.step] ? EVT_BTN_PRESS : EVT_BTN_RELEASE;
                wr_entry.code = 8'd1 << cmd.step;
            end
        end
    end

    assign push_go  = (cmd.push_key || cmd.push_mouse) && need;
    assign do_write = push_go && !full;

    // event memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (do_write)
            mem[wr_ptr_reg[IDX_W-1:0]] <= wr_entry;
        if (cmd.rd)
            rd_q <= mem[rd_ptr_reg[IDX_W-1:0]];
    end

    // item capture and per-item tallies
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            scancode_reg <= f_scancode;
            key_down_reg <= f_key_down;
            key_char_reg <= f_key_char;
            nx_reg       <= COORD_WIDTH'(f_mouse_x);
            ny_reg       <= COORD_WIDTH'(f_mouse_y);
            nb_reg       <= f_buttons;
            pushed_reg   <= 3'd0;
            dropped_reg  <= 3'd0;
            got_reg      <= 1'b0;
        end
        else
        begin
            if (do_write)
                pushed_reg <= pushed_reg + 3'd1;
            if (push_go && full)
                dropped_reg <= dropped_reg + 3'd1;
            if (cmd.rd && !empty)
                got_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            last_x_reg   <= '1;
            last_y_reg   <= '1;
            last_btn_reg <= 8'd0;
        end
        else
        begin
            if (do_write)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (cmd.rd && !empty)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (cmd.upd_last)
            begin
                last_x_reg   <= nx_reg;
                last_y_reg   <= ny_reg;
                last_btn_reg <= nb_reg;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_comb
    begin
        out_data_next        = '0;
        out_data_next[62:60] = pushed_reg;
        out_data_next[65:63] = dropped_reg;
        if (got_reg)
        begin
            out_data_next[0]     = 1'b1;
            out_data_next[3:1]   = rd_q.kind;
            out_data_next[11:4]  = rd_q.code;
            out_data_next[19:12] = rd_q.chr;
            out_data_next[27:20] = rd_q.btn;
            out_data_next[43:28] = 16'(rd_q.x);
            out_data_next[59:44] = 16'(rd_q.y);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            out_data_reg <= out_data_next;
    end

    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;
    assign status.in_action = f_action;
    assign status.out_free  = !out_valid_reg || out_ready;

endmodule

// File: sv/input_event_queue.sv
// ----------------------------------------------------------------------------
// input_event_queue
// Input event FIFO with mouse button edge and move detection.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_axis    in   action, scancode, key_down, key_char, mouse_x, mouse_y,
//                 mouse_buttons
//  m_axis    out  got_event, ev_type, ev_code, ev_char, ev_buttons, ev_x,
//                 ev_y, pushed_count, dropped_count
//
// One item at a time. After the accept, key items pass one queue-write state and poll
// items one read state before the result register loads; mouse items take a step per button
// bit and one for the move check, since every queued event goes through the
// single memory write port, and an unused action goes straight to the result.
// A waiting result does not stop the next item from being accepted; the item
// after that stalls until the result is taken.
// Reset clears pointers and buttons and sets the last position to all ones at once; no clearing pass.
// ----------------------------------------------------------------------------
module input_event_queue
#(
    parameter int QUEUE_DEPTH = ieq_pkg::QUEUE_DEPTH_DEF,
    parameter int COORD_WIDTH = ieq_pkg::COORD_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // action[1:0], scancode[9:2], key_down[10], key_char[18:11],
    // mouse_x[34:19], mouse_y[50:35], mouse_buttons[58:51], zero fill
    input  logic [ieq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // got_event[0], ev_type[3:1], ev_code[11:4], ev_char[19:12],
    // ev_buttons[27:20], ev_x[43:28], ev_y[59:44], pushed_count[62:60],
    // dropped_count[65:63], zero fill
    output logic [ieq_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import ieq_pkg::*;

    ieq_cmd_t    cmd;
    ieq_status_t status;

    ieq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ieq_datapath
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .COORD_WIDTH (COORD_WIDTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
